// ----- hdl/lspr_pkg.sv -----
package lspr_pkg;

   // Timer width of the limit registers; the elapsed counter carries one bit more.
   localparam int TIMER_WIDTH   = 16;
   localparam int ELAPSED_WIDTH = TIMER_WIDTH + 1;
   localparam int LIMIT_WIDTH   = 16;
   localparam int CMP_WIDTH     = (ELAPSED_WIDTH > LIMIT_WIDTH) ? ELAPSED_WIDTH : LIMIT_WIDTH;

   // Limit registers keep only TIMER_WIDTH bits when that is below 16.
   localparam logic [LIMIT_WIDTH-1:0] TIME_MASK =
      LIMIT_WIDTH'((64'd1 << TIMER_WIDTH) - 64'd1);

   localparam int RETRY_WIDTH = 3;
   localparam logic [RETRY_WIDTH-1:0] RETRY_SAT = '1;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_PULSE_TICKS    = 3'd0,
      CSR_SETTLE_TICKS   = 3'd1,
      CSR_RETRY_DELAY    = 3'd2,
      CSR_COOLDOWN_TICKS = 3'd3,
      CSR_MAX_RETRIES    = 3'd4
   } csr_index_type;

   localparam logic [LIMIT_WIDTH-1:0] PULSE_TICKS_RST    = 16'd500;
   localparam logic [LIMIT_WIDTH-1:0] SETTLE_TICKS_RST   = 16'd50;
   localparam logic [LIMIT_WIDTH-1:0] RETRY_DELAY_RST    = 16'd1000;
   localparam logic [LIMIT_WIDTH-1:0] COOLDOWN_TICKS_RST = 16'd2000;
   localparam logic [RETRY_WIDTH-1:0] MAX_RETRIES_RST    = 3'd3;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_PULSE  = 3'd1,
      PH_SETTLE = 3'd2,
      PH_RETRY  = 3'd3,
      PH_COOL   = 3'd4
   } phase_type;

   function automatic logic limit_passed(input logic [ELAPSED_WIDTH-1:0] elapsed,
                                         input logic [LIMIT_WIDTH-1:0] limit);
      return CMP_WIDTH'(elapsed) > CMP_WIDTH'(limit);
   endfunction

endpackage

// ----- hdl/lspr_if.sv -----
interface lspr_req_if;
   logic valid;
   logic ready;
   logic tick;
   logic open_request;
   logic lock_sensed_open;

   modport source (output valid, output tick, output open_request,
                   output lock_sensed_open, input ready);
   modport sink   (input valid, input tick, input open_request,
                   input lock_sensed_open, output ready);
endinterface

interface lspr_rsp_if;
   logic       valid;
   logic       ready;
   logic       relay_drive;
   logic       open_failed;
   logic [2:0] phase;
   logic       door_open_now;

   modport source (output valid, output relay_drive, output open_failed,
                   output phase, output door_open_now, input ready);
   modport sink   (input valid, input relay_drive, input open_failed,
                   input phase, input door_open_now, output ready);
endinterface

// ----- hdl/lock_strike_pulse_retry_ctrl.sv -----
// Channel   Dir  Payload                                        Handshake
// req_ch    in   tick, open_request, lock_sensed_open           valid/ready
// rsp_ch    out  relay_drive, open_failed, phase, door_open_now valid/ready
// csr_*     in   csr_index (3b), csr_wdata (16b)                csr_write_en, no wait
//
// One request per cycle while the response channel keeps taking responses: the whole
// state update is combinational logic from the state registers into the state and response registers.
// Each request gives one registered response in the cycle after it is accepted.
// Reset is synchronous and loads the default limits and the idle state.
// A request is taken while the response register is empty or being drained,
// so a stalled response holds the input off only while it waits.
module lock_strike_pulse_retry_ctrl (
   input  logic                                 clock,
   input  logic                                 reset,
   lspr_req_if.sink                             req_ch,
   lspr_rsp_if.source                           rsp_ch,
   input  logic                                 csr_write_en,
   input  logic [lspr_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [lspr_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   logic [lspr_pkg::LIMIT_WIDTH-1:0] pulse_ticks_ff, settle_ticks_ff;
   logic [lspr_pkg::LIMIT_WIDTH-1:0] retry_delay_ff, cooldown_ticks_ff;
   logic [lspr_pkg::RETRY_WIDTH-1:0] max_retries_ff;

   lspr_pkg::phase_type                phase_ff, phase_in;
   logic [lspr_pkg::ELAPSED_WIDTH-1:0] elapsed_ff, elapsed_in, elapsed_inc;
   logic                               latch_ff, latch_in, latch_set;
   logic                               failed_ff, failed_in;
   logic [lspr_pkg::RETRY_WIDTH-1:0]   retry_ff, retry_in;
   logic                               relay_ff, relay_in;

   logic       rsp_valid_ff;
   logic       relay_drive_ff, open_failed_ff, door_open_ff;
   logic [2:0] phase_out_ff;

   logic req_accept;
   logic pulse_done, settle_done, retry_done, cool_done, may_retry;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_accept   = req_ch.valid && req_ch.ready;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_ticks_ff    <= lspr_pkg::PULSE_TICKS_RST;
         settle_ticks_ff   <= lspr_pkg::SETTLE_TICKS_RST;
         retry_delay_ff    <= lspr_pkg::RETRY_DELAY_RST;
         cooldown_ticks_ff <= lspr_pkg::COOLDOWN_TICKS_RST;
         max_retries_ff    <= lspr_pkg::MAX_RETRIES_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            lspr_pkg::CSR_PULSE_TICKS:    pulse_ticks_ff    <= csr_wdata & lspr_pkg::TIME_MASK;
            lspr_pkg::CSR_SETTLE_TICKS:   settle_ticks_ff   <= csr_wdata & lspr_pkg::TIME_MASK;
            lspr_pkg::CSR_RETRY_DELAY:    retry_delay_ff    <= csr_wdata & lspr_pkg::TIME_MASK;
            lspr_pkg::CSR_COOLDOWN_TICKS: cooldown_ticks_ff <= csr_wdata & lspr_pkg::TIME_MASK;
            lspr_pkg::CSR_MAX_RETRIES:
               max_retries_ff <= csr_wdata[lspr_pkg::RETRY_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Saturating tick count, then the limit checks of each phase
   assign latch_set   = latch_ff || req_ch.open_request;
   assign elapsed_inc = (req_ch.tick && (elapsed_ff != '1))
                        ? elapsed_ff + lspr_pkg::ELAPSED_WIDTH'(1) : elapsed_ff;
   assign pulse_done  = lspr_pkg::limit_passed(elapsed_inc, pulse_ticks_ff);
   assign settle_done = lspr_pkg::limit_passed(elapsed_inc, settle_ticks_ff);
   assign retry_done  = lspr_pkg::limit_passed(elapsed_inc, retry_delay_ff);
   assign cool_done   = lspr_pkg::limit_passed(elapsed_inc, cooldown_ticks_ff);
   assign may_retry   = retry_ff < max_retries_ff;

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         lspr_pkg::PH_PULSE:  if (pulse_done) phase_in = lspr_pkg::PH_SETTLE;
         lspr_pkg::PH_SETTLE: begin
            if (settle_done) begin
               phase_in = (req_ch.lock_sensed_open || !may_retry)
                          ? lspr_pkg::PH_COOL : lspr_pkg::PH_RETRY;
            end
         end
         lspr_pkg::PH_RETRY:  if (retry_done) phase_in = lspr_pkg::PH_IDLE;
         lspr_pkg::PH_COOL:   if (cool_done) phase_in = lspr_pkg::PH_IDLE;
         default: phase_in = latch_set ? lspr_pkg::PH_PULSE : lspr_pkg::PH_IDLE;
      endcase
   end

   // Timer, latch, flag, retry count and relay
   always_comb begin
      elapsed_in = (phase_in != phase_ff) ? '0 : elapsed_inc;
      latch_in   = latch_set;
      failed_in  = failed_ff;
      retry_in   = retry_ff;
      relay_in   = relay_ff;
      unique case (phase_ff)
         lspr_pkg::PH_PULSE:  if (pulse_done) relay_in = 1'b0;
         lspr_pkg::PH_SETTLE: begin
            if (settle_done && !req_ch.lock_sensed_open) begin
               if (retry_ff != lspr_pkg::RETRY_SAT) begin
                  retry_in = retry_ff + lspr_pkg::RETRY_WIDTH'(1);
               end
               if (!may_retry) failed_in = 1'b1;
            end
         end
         lspr_pkg::PH_RETRY: ;
         lspr_pkg::PH_COOL: begin
            // cooldown end wins over a request on the same item
            if (cool_done) begin
               retry_in  = '0;
               latch_in  = 1'b0;
               failed_in = 1'b0;
            end
         end
         default: if (latch_set) relay_in = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= lspr_pkg::PH_IDLE;
         elapsed_ff <= '0;
         latch_ff   <= 1'b0;
         failed_ff  <= 1'b0;
         retry_ff   <= '0;
         relay_ff   <= 1'b0;
      end else if (req_accept) begin
         phase_ff   <= phase_in;
         elapsed_ff <= elapsed_in;
         latch_ff   <= latch_in;
         failed_ff  <= failed_in;
         retry_ff   <= retry_in;
         relay_ff   <= relay_in;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         rsp_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         relay_drive_ff <= relay_in;
         open_failed_ff <= failed_in;
         phase_out_ff   <= phase_in;
         door_open_ff   <= req_ch.lock_sensed_open;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.relay_drive   = relay_drive_ff;
   assign rsp_ch.open_failed   = open_failed_ff;
   assign rsp_ch.phase         = phase_out_ff;
   assign rsp_ch.door_open_now = door_open_ff;

endmodule
